[hw/rtl/pidec_pkg.sv]
// pidec_pkg: shared types, codes and channel expansion for the palette index decoder
// no dependencies; imported by the front, queue, back, top and checker rtl files
package pidec_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int IDX_W               = 8;
	localparam int WORD_W              = 16;
	localparam int CH_W                = 8;
	localparam int QUEUE_DEPTH         = 4;
	localparam int PADDR_W             = 3;
	localparam int PDATA_W             = 32;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam logic CI_MODE_4     = 1'b0;
	localparam logic CI_MODE_8     = 1'b1;
	localparam logic CI_MODE_RESET = CI_MODE_8;

	localparam logic [0:0] REG_CI_MODE = 1'b0;

	typedef struct packed {
		logic              is_load;
		logic              in_range;
		logic [IDX_W-1:0]  index;
		logic [WORD_W-1:0] word;
		logic              run_last;
		logic              frame_last;
	} qentry_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
	} pixel_t;

	// floor(v*255/31) as 8v plus a small step correction
	function automatic logic [CH_W-1:0] widen5(input logic [4:0] v);
		logic [2:0] corr;
		corr = 3'd0;
		if (v >= 5'd5)  corr = 3'd1;
		if (v >= 5'd9)  corr = 3'd2;
		if (v >= 5'd14) corr = 3'd3;
		if (v >= 5'd18) corr = 3'd4;
		if (v >= 5'd23) corr = 3'd5;
		if (v >= 5'd27) corr = 3'd6;
		if (v == 5'd31) corr = 3'd7;
		return {v, 3'b000} + CH_W'(corr);
	endfunction

	function automatic pixel_t expand(input logic [WORD_W-1:0] w);
		pixel_t p;
		p.red   = widen5(w[15:11]);
		p.green = widen5(w[10:6]);
		p.blue  = widen5(w[5:1]);
		p.alpha = w[0] ? 8'hFF : 8'h00;
		return p;
	endfunction

endpackage

[hw/rtl/pidec_if.sv]
// pidec_in_if / pidec_out_if: valid-ready channels for input items and result pixels
// no dependencies
interface pidec_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] entry_index;
	logic [15:0] entry_word;
	logic [7:0] pixel_byte;
	logic       frame_end;

	modport source(output valid, operation, entry_index, entry_word, pixel_byte, frame_end,
		input ready);
	modport sink(input valid, operation, entry_index, entry_word, pixel_byte, frame_end,
		output ready);
endinterface

interface pidec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       run_last;
	logic       frame_last;

	modport source(output valid, red, green, blue, alpha, run_last, frame_last, input ready);
	modport sink(input valid, red, green, blue, alpha, run_last, frame_last, output ready);
endinterface

[hw/rtl/pidec_front.sv]
// pidec_front: accepts input beats, classifies them and splits ci4 bytes into two lookups
// depends on pidec_pkg and pidec_in_if
module pidec_front #(
	parameter int PALETTE_ENTRIES = pidec_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ci_mode,
	pidec_in_if.sink          pix_in,
	output logic              push_valid,
	input  logic              push_ready,
	output pidec_pkg::qentry_t push_data
);
	import pidec_pkg::*;

	logic    pend_q;
	qentry_t pend_entry_q;
	qentry_t in_entry;
	logic    in_acc;
	logic    split;

	function automatic logic in_store(input logic [IDX_W-1:0] idx);
		return {1'b0, idx} < (IDX_W+1)'(PALETTE_ENTRIES);
	endfunction

	always_comb begin
		in_entry = '0;
		if (pix_in.operation == OP_LOAD) begin
			in_entry.is_load  = 1'b1;
			in_entry.index    = pix_in.entry_index;
			in_entry.word     = pix_in.entry_word;
			in_entry.in_range = in_store(pix_in.entry_index);
		end else if (ci_mode == CI_MODE_8) begin
			in_entry.index      = pix_in.pixel_byte;
			in_entry.in_range   = in_store(pix_in.pixel_byte);
			in_entry.run_last   = 1'b1;
			in_entry.frame_last = pix_in.frame_end;
		end else begin
			in_entry.index    = {4'h0, pix_in.pixel_byte[7:4]};
			in_entry.in_range = in_store({4'h0, pix_in.pixel_byte[7:4]});
		end
	end

	assign pix_in.ready = !pend_q && push_ready;
	assign in_acc       = pix_in.valid && pix_in.ready;
	assign split        = in_acc && (pix_in.operation == OP_PIXEL) && (ci_mode == CI_MODE_4);
	assign push_valid   = pend_q || pix_in.valid;
	assign push_data    = pend_q ? pend_entry_q : in_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (split) begin
			pend_q <= 1'b1;
		end else if (pend_q && push_ready) begin
			pend_q <= 1'b0;
		end
	end

	// low nibble waits here for its slot in the queue
	always_ff @(posedge clk) begin
		if (split) begin
			pend_entry_q.is_load    <= 1'b0;
			pend_entry_q.index      <= {4'h0, pix_in.pixel_byte[3:0]};
			pend_entry_q.in_range   <= in_store({4'h0, pix_in.pixel_byte[3:0]});
			pend_entry_q.word       <= '0;
			pend_entry_q.run_last   <= 1'b1;
			pend_entry_q.frame_last <= pix_in.frame_end;
		end
	end

endmodule

[hw/rtl/pidec_queue.sv]
// pidec_queue: short fifo of classified entries between front and back
// depends on pidec_pkg
module pidec_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  pidec_pkg::qentry_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output pidec_pkg::qentry_t pop_data
);
	import pidec_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	qentry_t         slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = count_q != CW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= bump(wptr_q);
			if (pop)  rptr_q <= bump(rptr_q);
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= push_data;
	end

endmodule

[hw/rtl/pidec_back.sv]
// pidec_back: palette store, registered lookup and channel expansion into the output register
// depends on pidec_pkg and pidec_out_if
module pidec_back #(
	parameter int PALETTE_ENTRIES = pidec_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  pidec_pkg::qentry_t pop_data,
	pidec_out_if.source        pix_out
);
	import pidec_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic [WORD_W-1:0] palette_mem [PALETTE_ENTRIES];

	logic [WORD_W-1:0] rd_word_s1;
	logic              in_range_s1;
	logic              run_last_s1;
	logic              frame_last_s1;
	logic              valid_s1;

	pixel_t            pixel_s2;
	logic              run_last_s2;
	logic              frame_last_s2;
	logic              valid_s2;

	logic              adv;
	logic              take;
	logic              pop;
	logic              wr;
	logic              rd;
	logic [AW-1:0]     addr;

	assign adv       = !valid_s2 || pix_out.ready;
	assign take      = !valid_s1 || adv;
	assign pop_ready = pop_data.is_load || take;
	assign pop       = pop_valid && pop_ready;
	assign wr        = pop && pop_data.is_load && pop_data.in_range;
	assign rd        = pop && !pop_data.is_load;
	assign addr      = pop_data.index[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr) palette_mem[addr] <= pop_data.word;
		if (rd) begin
			rd_word_s1    <= palette_mem[addr];
			in_range_s1   <= pop_data.in_range;
			run_last_s1   <= pop_data.run_last;
			frame_last_s1 <= pop_data.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rd) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) valid_s2 <= valid_s1;
		end
	end

	// out of range index reads as an all-zero pixel
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			pixel_s2      <= expand(in_range_s1 ? rd_word_s1 : '0);
			run_last_s2   <= run_last_s1;
			frame_last_s2 <= frame_last_s1;
		end
	end

	assign pix_out.valid      = valid_s2;
	assign pix_out.red        = pixel_s2.red;
	assign pix_out.green      = pixel_s2.green;
	assign pix_out.blue       = pixel_s2.blue;
	assign pix_out.alpha      = pixel_s2.alpha;
	assign pix_out.run_last   = run_last_s2;
	assign pix_out.frame_last = frame_last_s2;

endmodule

[hw/rtl/palette_index_pixel_decoder_top.sv]
// palette_index_pixel_decoder_top: register port, front, queue and back of the decoder
// depends on pidec_pkg, pidec_if, pidec_front, pidec_queue and pidec_back
//
// Decodes color-indexed bytes to RGBA8888 through a palette of RGBA5551 words. A load beat
// writes one palette entry; a CI8 pixel byte gives one pixel; a CI4 byte gives two pixels,
// high nibble first, and holds off further input until its low nibble is queued, since the
// front splits it into two lookups over the single palette read port and the single result
// channel. A pixel passes through the queue, the registered palette read and the expansion
// register before it is valid at the output. A four-entry queue between front and back, plus
// a registered output, lets input continue while a result waits. ci_mode sits at byte
// address 0 (reset 1, eight-bit indices); the user must write it only while the block is
// idle; the block does not enforce this. Palette entries are undefined until loaded.
module palette_index_pixel_decoder_top #(
	parameter int PALETTE_ENTRIES = pidec_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pidec_pkg::PADDR_W-1:0]  paddr,
	input  logic [pidec_pkg::PDATA_W-1:0]  pwdata,
	output logic [pidec_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready,
	pidec_in_if.sink                       pix_in,
	pidec_out_if.source                    pix_out
);
	import pidec_pkg::*;

	logic       ci_mode_q;
	logic       cfg_wr;
	logic [0:0] reg_idx;
	logic       push_valid;
	logic       push_ready;
	qentry_t    push_data;
	logic       pop_valid;
	logic       pop_ready;
	qentry_t    pop_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == REG_CI_MODE) ? {{(PDATA_W-1){1'b0}}, ci_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_mode_q <= CI_MODE_RESET;
		end else if (cfg_wr && (reg_idx == REG_CI_MODE)) begin
			ci_mode_q <= pwdata[0];
		end
	end

	pidec_front #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ci_mode   (ci_mode_q),
		.pix_in    (pix_in),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	pidec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	pidec_back #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.pix_out  (pix_out)
	);

endmodule

[hw/rtl/pidec_checker.sv]
// pidec_checker: port-level assertions on the decoder, attached to the top level by bind
// depends on pidec_pkg and palette_index_pixel_decoder_top
module pidec_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_operation,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [7:0] out_alpha,
	input logic       out_run_last,
	input logic       out_frame_last
);
	import pidec_pkg::*;

	logic seen_q;

	// a pixel beat has been taken since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (in_valid && in_ready && (in_operation == OP_PIXEL)) begin
			seen_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({out_red, out_green, out_blue, out_alpha,
			out_run_last, out_frame_last}))
		else $error("result payload changed while stalled");

	a_frame_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_frame_last |-> out_run_last)
		else $error("frame end on a pixel that is not the last of its byte");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(seen_q, 2))
		else $error("result beat without an earlier pixel beat");

endmodule

bind palette_index_pixel_decoder_top pidec_checker u_pidec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (pix_in.valid),
	.in_ready      (pix_in.ready),
	.in_operation  (pix_in.operation),
	.out_valid     (pix_out.valid),
	.out_ready     (pix_out.ready),
	.out_red       (pix_out.red),
	.out_green     (pix_out.green),
	.out_blue      (pix_out.blue),
	.out_alpha     (pix_out.alpha),
	.out_run_last  (pix_out.run_last),
	.out_frame_last(pix_out.frame_last)
);

[sim/pixel_decode_checker.sv]
`timescale 1ns / 1ps
// pixel_decode_checker: watches the register port and both pixel channels, predicts each
// RGBA8888 pixel from its own palette copy and compares; depends on pidec_pkg and pidec_if
module pixel_decode_checker #(
	parameter int PALETTE_ENTRIES = pidec_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [pidec_pkg::PADDR_W-1:0] paddr,
	input  logic [pidec_pkg::PDATA_W-1:0] pwdata,
	pidec_in_if                           in_ch,
	pidec_out_if                          out_ch,
	output int                            failures,
	output int                            pending
);
	import pidec_pkg::*;

	localparam logic [PADDR_W-1:0] CI_MODE_ADDR = PADDR_W'(4 * REG_CI_MODE);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       run_last;
		logic       frame_last;
	} rgba_px_t;

	rgba_px_t    px_fifo[$];
	logic [15:0] palette [PALETTE_ENTRIES];
	logic        ci_mode;
	int          fail_cnt = 0;
	int          pend_cnt = 0;

	assign failures = fail_cnt;
	assign pending  = pend_cnt;

	function automatic logic [7:0] stretch5(input logic [4:0] v);
		return 8'((32'(v) * 255) / 31);
	endfunction

	function automatic rgba_px_t lookup(input int idx, input logic rl, input logic fl);
		logic [15:0] w;
		rgba_px_t    p;
		w = '0;
		if (idx < PALETTE_ENTRIES)
			w = palette[idx];
		p.red        = stretch5(w[15:11]);
		p.green      = stretch5(w[10:6]);
		p.blue       = stretch5(w[5:1]);
		p.alpha      = (w[0] && idx < PALETTE_ENTRIES) ? 8'hFF : 8'h00;
		p.run_last   = rl;
		p.frame_last = fl;
		return p;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		rgba_px_t want;
		if (!arst_n) begin
			px_fifo.delete();
			ci_mode = CI_MODE_RESET;
			pend_cnt <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == CI_MODE_ADDR)
				ci_mode = pwdata[0];

			if (out_ch.valid && out_ch.ready) begin
				if (px_fifo.size() == 0) begin
					$error("pixel with no expectation waiting");
					fail_cnt++;
				end else begin
					want = px_fifo.pop_front();
					check_field("red", want.red, out_ch.red);
					check_field("green", want.green, out_ch.green);
					check_field("blue", want.blue, out_ch.blue);
					check_field("alpha", want.alpha, out_ch.alpha);
					check_field("run_last", want.run_last, out_ch.run_last);
					check_field("frame_last", want.frame_last, out_ch.frame_last);
				end
			end

			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.operation == OP_LOAD) begin
					if (int'(in_ch.entry_index) < PALETTE_ENTRIES)
						palette[in_ch.entry_index] = in_ch.entry_word;
				end else if (ci_mode == CI_MODE_4) begin
					// high nibble first
					px_fifo.push_back(lookup(int'(in_ch.pixel_byte[7:4]), 1'b0, 1'b0));
					px_fifo.push_back(lookup(int'(in_ch.pixel_byte[3:0]), 1'b1,
						in_ch.frame_end));
				end else begin
					px_fifo.push_back(lookup(int'(in_ch.pixel_byte), 1'b1, in_ch.frame_end));
				end
			end

			pend_cnt <= px_fifo.size();
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench: drives palette loads, CI4/CI8 pixel bytes and ci_mode writes into the decoder
// under several idling patterns; depends on pidec_pkg, pidec_if, the rtl and pixel_decode_checker
module testbench;
	import pidec_pkg::*;

	localparam int ENTRIES         = PALETTE_ENTRIES_DEF;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 16;
	localparam int ITEMS_PER_PHASE = 142;
	localparam int NUM_PHASES      = 8;
	localparam logic [PADDR_W-1:0] CI_MODE_ADDR = PADDR_W'(4 * REG_CI_MODE);

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int   failures;
	int   pending;
	int   cycle_cnt;
	int   src_idle_pct;
	int   sink_stall_pct;
	logic hold_tog;
	int   load_cnt;
	int   byte_cnt;
	bit   loaded [ENTRIES];
	int   ci8_ids[$];
	int   ci4_ids[$];

	pidec_in_if  pix_in();
	pidec_out_if pix_out();

	palette_index_pixel_decoder_top #(.PALETTE_ENTRIES(ENTRIES)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pix_in(pix_in), .pix_out(pix_out)
	);

	pixel_decode_checker #(.PALETTE_ENTRIES(ENTRIES)) chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_ch(pix_in), .out_ch(pix_out),
		.failures(failures), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Mismatches found");
		$finish;
	end

	// receiver: random stalls plus one long hold-off per toggle of hold_tog
	initial begin : receiver
		logic hold_seen;
		int   hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		pix_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_tog != hold_seen) begin
				hold_seen = hold_tog;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_out.ready <= 1'b0;
			end else begin
				pix_out.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_item(input logic op, input logic [7:0] idx, input logic [15:0] word,
		input logic [7:0] pb, input logic fend);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid       <= 1'b1;
		pix_in.operation   <= op;
		pix_in.entry_index <= idx;
		pix_in.entry_word  <= word;
		pix_in.pixel_byte  <= pb;
		pix_in.frame_end   <= fend;
		do @(posedge clk); while (!pix_in.ready);
		if (op == OP_LOAD) begin
			load_cnt++;
			if (int'(idx) < ENTRIES && !loaded[idx]) begin
				loaded[idx] = 1'b1;
				ci8_ids.push_back(int'(idx));
				if (idx < 8'd16)
					ci4_ids.push_back(int'(idx));
			end
		end else begin
			byte_cnt++;
		end
	endtask

	task automatic load_entry(input logic [7:0] idx, input logic [15:0] word);
		send_item(OP_LOAD, idx, word, 8'($urandom), 1'($urandom));
	endtask

	task automatic decode_byte(input logic [7:0] pb, input logic fend);
		send_item(OP_PIXEL, 8'($urandom), 16'($urandom), pb, fend);
	endtask

	// only indices already loaded are ever decoded
	task automatic random_item(input logic mode);
		logic [7:0] pb;
		logic [7:0] idx;
		logic       no_ids;
		no_ids = (mode == CI_MODE_8) ? (ci8_ids.size() == 0) : (ci4_ids.size() == 0);
		if ($urandom_range(99) < 30 || no_ids) begin
			idx = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
			load_entry(idx, 16'($urandom));
		end else begin
			if (mode == CI_MODE_8)
				pb = 8'(ci8_ids[$urandom_range(ci8_ids.size() - 1)]);
			else
				pb = {4'(ci4_ids[$urandom_range(ci4_ids.size() - 1)]),
					4'(ci4_ids[$urandom_range(ci4_ids.size() - 1)])};
			decode_byte(pb, $urandom_range(9) == 0);
		end
	endtask

	task automatic drain_results();
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_ci_mode(input logic mode);
		apb_write(CI_MODE_ADDR, PDATA_W'(mode));
	endtask

	initial begin : stimulus
		logic mode;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		pix_in.valid       = 1'b0;
		pix_in.operation   = OP_LOAD;
		pix_in.entry_index = '0;
		pix_in.entry_word  = '0;
		pix_in.pixel_byte  = '0;
		pix_in.frame_end   = 1'b0;
		hold_tog           = 1'b0;
		src_idle_pct       = 0;
		sink_stall_pct     = 0;
		load_cnt           = 0;
		byte_cnt           = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// eight-bit mode out of reset
		load_entry(8'h00, 16'h0000);
		load_entry(8'hFF, 16'hFFFF);
		load_entry(8'h01, 16'hFFFE);
		load_entry(8'h0F, 16'h0001);
		load_entry(8'h80, 16'h07C1);
		decode_byte(8'h00, 1'b0);
		decode_byte(8'hFF, 1'b0);
		decode_byte(8'h01, 1'b0);
		decode_byte(8'h0F, 1'b0);
		decode_byte(8'h80, 1'b1);
		drain_results();

		// four-bit mode, nibbles from entries 0, 1 and 15
		set_ci_mode(CI_MODE_4);
		decode_byte(8'h0F, 1'b0);
		decode_byte(8'hF0, 1'b0);
		decode_byte(8'h00, 1'b0);
		decode_byte(8'hFF, 1'b1);
		decode_byte(8'h1F, 1'b0);
		decode_byte(8'hF1, 1'b1);
		drain_results();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			mode = (phase % 2 == 0) ? CI_MODE_8 : CI_MODE_4;
			case (phase / 2)
				0: begin
					src_idle_pct   <= 0;
					sink_stall_pct <= 0;
				end
				1: begin
					src_idle_pct   <= 81;
					sink_stall_pct <= 0;
				end
				2: begin
					src_idle_pct   <= 0;
					sink_stall_pct <= 81;
				end
				default: begin
					src_idle_pct   <= 6;
					sink_stall_pct <= 6;
				end
			endcase
			set_ci_mode(mode);
			if (phase == 1)
				hold_tog <= ~hold_tog;
			repeat (ITEMS_PER_PHASE) random_item(mode);
			drain_results();
		end

		$display("Sent %0d palette loads and %0d pixel bytes in CI8 and CI4 mode", load_cnt,
			byte_cnt);
		$display("with free flow, sender gaps, receiver stalls and a long output hold-off");
		if (failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
